>>> rtl/atgc_pkg.sv
// shared types, constants and helpers of the allele tally and genotype coder
// no dependencies; every rtl file refers to it by scoped names
package atgc_pkg;

    localparam int MaxAlts = 16;
    localparam int IdxW    = (MaxAlts > 1) ? $clog2(MaxAlts) : 1;
    localparam int EntW    = $clog2(MaxAlts + 1);
    localparam int CntW    = 13;
    localparam int CodeW   = 5;

    localparam logic [CntW-1:0] CntMax     = {CntW{1'b1}};
    localparam logic [7:0]      NoCallByte = 8'h2E;

    localparam logic [1:0] KindGenotype = 2'd0;
    localparam logic [1:0] KindAlt      = 2'd1;
    localparam logic [1:0] KindSummary  = 2'd2;

    typedef struct packed {
        logic [7:0] ref_base;
        logic [7:0] sample_allele;
        logic       last_sample;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       record_kind;
        logic [CodeW-1:0] genotype_code;
        logic             no_call;
        logic             overflow;
        logic [7:0]       alt_base;
        logic [CntW-1:0]  alt_observations;
        logic [CodeW-1:0] alt_total;
        logic [CntW-1:0]  no_call_total;
        logic [CntW-1:0]  called_total;
        logic             last;
    } out_item_t;

    typedef enum logic [1:0] {
        CLS_REF,
        CLS_NOCALL,
        CLS_ALT
    } allele_cls_t;

    // classified item as it travels from front to back
    typedef struct packed {
        allele_cls_t cls;
        logic [7:0]  allele;
        logic        last;
    } cls_item_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic      valid;
        cls_item_t item;
    } q_head_t;

    typedef enum logic [1:0] {
        S_RUN,
        S_ALTS,
        S_SUM
    } back_state_t;

    function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
        sat_inc = (v == CntMax) ? CntMax : v + CntW'(1);
    endfunction

endpackage

>>> rtl/allele_tally_genotype_coder.sv
// Allele tally and genotype coder, top level: front classifier, queue, back end.
// A sample is held in the queue, its genotype in the output register; in steady
// state, barring stalls and position ends, one sample is accepted and one genotype
// delivered per cycle, set by the parallel compare against the alt table in the
// back end. A last sample yields its genotype, then one alt record per cycle in
// first-seen order unless the output stalls, then the position summary, after
// which the position tallies clear. Output is held in one register, so a stalled
// result leaves the two-entry queue free to take further samples. Depends on atgc_pkg.
module allele_tally_genotype_coder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  atgc_pkg::in_item_t  sample,
    output logic                result_valid,
    input  logic                result_stall,
    output atgc_pkg::out_item_t result
);

    atgc_pkg::cls_item_t cls_item;
    atgc_pkg::q_head_t   head;
    logic                q_full;
    logic                q_pop;

    assign sample_stall = q_full;

    atgc_front u_front (
        .item     (sample),
        .cls_item (cls_item)
    );

    atgc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (sample_valid),
        .push_item (cls_item),
        .full      (q_full),
        .pop       (q_pop),
        .head      (head)
    );

    atgc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

>>> rtl/atgc_front.sv
// front end: classifies each sample allele against the reference base
// depends on atgc_pkg
module atgc_front (
    input  atgc_pkg::in_item_t  item,
    output atgc_pkg::cls_item_t cls_item
);

    always_comb
    begin
        cls_item.allele = item.sample_allele;
        cls_item.last   = item.last_sample;
        // reference compare wins over the no-call byte
        if (item.sample_allele == item.ref_base || item.sample_allele == 8'd0)
        begin
            cls_item.cls = atgc_pkg::CLS_REF;
        end
        else if (item.sample_allele == atgc_pkg::NoCallByte)
        begin
            cls_item.cls = atgc_pkg::CLS_NOCALL;
        end
        else
        begin
            cls_item.cls = atgc_pkg::CLS_ALT;
        end
    end

endmodule

>>> rtl/atgc_queue.sv
// two-entry queue of classified items between front and back end
// depends on atgc_pkg
module atgc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  atgc_pkg::cls_item_t push_item,
    output logic                full,
    input  logic                pop,
    output atgc_pkg::q_head_t   head
);

    atgc_pkg::cls_item_t slot_reg [2];
    logic [1:0] count_reg, count_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       do_push, do_pop;

    assign full       = (count_reg == 2'd2);
    assign do_push    = push && !full;
    assign do_pop     = pop && (count_reg != 2'd0);
    assign head.valid = (count_reg != 2'd0);
    assign head.item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/atgc_back.sv
// back end: alt table lookup, tallies, genotype results, alt records and summary
// depends on atgc_pkg
module atgc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  atgc_pkg::q_head_t    head,
    output logic                 pop,
    output logic                 result_valid,
    input  logic                 result_stall,
    output atgc_pkg::out_item_t  result
);

    localparam int IdxW = atgc_pkg::IdxW;
    localparam int EntW = atgc_pkg::EntW;
    localparam int CntW = atgc_pkg::CntW;

    logic [7:0]      table_reg [atgc_pkg::MaxAlts];
    logic [CntW-1:0] cnt_reg   [atgc_pkg::MaxAlts];

    atgc_pkg::back_state_t state_reg, state_next;
    logic [EntW-1:0] entries_reg, entries_next;
    logic [CntW-1:0] nc_reg, nc_next;
    logic [CntW-1:0] seen_reg, seen_next;
    logic            ovf_reg, ovf_next;
    logic [IdxW-1:0] dump_reg, dump_next;
    logic            out_valid_reg, out_valid_next;
    atgc_pkg::out_item_t out_reg, out_next;

    logic [atgc_pkg::MaxAlts-1:0] hit_vec;
    logic            hit_any;
    logic [IdxW-1:0] hit_idx;
    logic            tbl_full;
    logic            slot_free;
    logic            dump_done;
    logic [IdxW-1:0] cnt_rd_idx;
    logic [CntW-1:0] cnt_rd;
    logic            tbl_we;
    logic            cnt_we;
    logic [IdxW-1:0] wr_idx;
    logic [CntW-1:0] cnt_wr_data;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign slot_free    = !out_valid_reg || !result_stall;
    assign tbl_full     = (entries_reg == EntW'(atgc_pkg::MaxAlts));
    assign dump_done    = ((EntW'(dump_reg) + EntW'(1)) == entries_reg);
    assign cnt_rd_idx   = (state_reg == atgc_pkg::S_ALTS) ? dump_reg : hit_idx;
    assign cnt_rd       = cnt_reg[cnt_rd_idx];

    // parallel compare over the valid part of the table
    always_comb
    begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < atgc_pkg::MaxAlts; i++)
        begin
            hit_vec[i] = (EntW'(i) < entries_reg) && (table_reg[i] == head.item.allele);
        end
        for (int i = atgc_pkg::MaxAlts - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_any = 1'b1;
                hit_idx = IdxW'(i);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            atgc_pkg::S_RUN:
            begin
                if (head.valid && slot_free && head.item.last)
                begin
                    state_next = (entries_next == '0) ? atgc_pkg::S_SUM : atgc_pkg::S_ALTS;
                end
            end
            atgc_pkg::S_ALTS:
            begin
                if (slot_free && dump_done)
                begin
                    state_next = atgc_pkg::S_SUM;
                end
            end
            atgc_pkg::S_SUM:
            begin
                if (slot_free)
                begin
                    state_next = atgc_pkg::S_RUN;
                end
            end
            default:
            begin
                state_next = atgc_pkg::S_RUN;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        pop            = 1'b0;
        entries_next   = entries_reg;
        nc_next        = nc_reg;
        seen_next      = seen_reg;
        ovf_next       = ovf_reg;
        dump_next      = dump_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;
        tbl_we         = 1'b0;
        cnt_we         = 1'b0;
        wr_idx         = hit_idx;
        cnt_wr_data    = atgc_pkg::sat_inc(cnt_rd);
        case (state_reg)
            atgc_pkg::S_RUN:
            begin
                if (head.valid && slot_free)
                begin
                    pop                    = 1'b1;
                    out_valid_next         = 1'b1;
                    out_next               = '0;
                    out_next.record_kind   = atgc_pkg::KindGenotype;
                    seen_next              = atgc_pkg::sat_inc(seen_reg);
                    dump_next              = '0;
                    case (head.item.cls)
                        atgc_pkg::CLS_NOCALL:
                        begin
                            out_next.no_call = 1'b1;
                            nc_next          = atgc_pkg::sat_inc(nc_reg);
                        end
                        atgc_pkg::CLS_ALT:
                        begin
                            if (hit_any)
                            begin
                                cnt_we                 = 1'b1;
                                out_next.genotype_code =
                                    atgc_pkg::CodeW'(EntW'(hit_idx) + EntW'(1));
                            end
                            else if (!tbl_full)
                            begin
                                tbl_we                 = 1'b1;
                                cnt_we                 = 1'b1;
                                wr_idx                 = entries_reg[IdxW-1:0];
                                cnt_wr_data            = CntW'(1);
                                entries_next           = entries_reg + EntW'(1);
                                out_next.genotype_code =
                                    atgc_pkg::CodeW'(entries_reg + EntW'(1));
                            end
                            else
                            begin
                                out_next.overflow = 1'b1;
                                ovf_next          = 1'b1;
                            end
                        end
                        default:
                        begin
                            out_next.genotype_code = '0;
                        end
                    endcase
                end
            end
            atgc_pkg::S_ALTS:
            begin
                if (slot_free)
                begin
                    out_valid_next            = 1'b1;
                    out_next                  = '0;
                    out_next.record_kind      = atgc_pkg::KindAlt;
                    out_next.genotype_code    = atgc_pkg::CodeW'(EntW'(dump_reg) + EntW'(1));
                    out_next.alt_base         = table_reg[dump_reg];
                    out_next.alt_observations = cnt_rd;
                    out_next.alt_total        = atgc_pkg::CodeW'(entries_reg);
                    dump_next                 = dump_reg + IdxW'(1);
                end
            end
            atgc_pkg::S_SUM:
            begin
                if (slot_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next               = '0;
                    out_next.record_kind   = atgc_pkg::KindSummary;
                    out_next.overflow      = ovf_reg;
                    out_next.alt_total     = atgc_pkg::CodeW'(entries_reg);
                    out_next.no_call_total = nc_reg;
                    out_next.called_total  = seen_reg - nc_reg;
                    out_next.last          = 1'b1;
                    // position done, start the next one empty
                    entries_next           = '0;
                    nc_next                = '0;
                    seen_next              = '0;
                    ovf_next               = 1'b0;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= atgc_pkg::S_RUN;
            entries_reg   <= '0;
            nc_reg        <= '0;
            seen_reg      <= '0;
            ovf_reg       <= 1'b0;
            dump_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            entries_reg   <= entries_next;
            nc_reg        <= nc_next;
            seen_reg      <= seen_next;
            ovf_reg       <= ovf_next;
            dump_reg      <= dump_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (tbl_we)
        begin
            table_reg[wr_idx] <= head.item.allele;
        end
        if (cnt_we)
        begin
            cnt_reg[wr_idx] <= cnt_wr_data;
        end
    end

endmodule
